[design/pca3_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pca3_pkg: shared types and constants
// Cell type codes, coordinate widths, item kinds and the controller states
// of the 3D parity automaton.
// ----------------------------------------------------------------------------
package pca3_pkg;

    localparam int MAX_RADIUS = 15;
    localparam int TYPE_BITS  = 4;
    localparam int COORD_W    = 5;
    localparam int ADDR_W     = 3 * COORD_W;
    localparam int DEPTH      = 1 << ADDR_W;

    typedef logic [TYPE_BITS-1:0] t_cell;
    typedef logic [COORD_W-1:0]   t_coord;
    typedef logic [ADDR_W-1:0]    t_addr;

    localparam t_cell T_EMPTY    = t_cell'(0);
    localparam t_cell T_CONCRETE = t_cell'(1);
    localparam t_cell T_MARKER   = t_cell'(2);

    typedef enum logic [1:0] {
        K_WRITE = 2'd0,
        K_READ  = 2'd1,
        K_GEN   = 2'd2,
        K_SCAN  = 2'd3
    } t_kind;

    // neighbor offset select: minus one, same, plus one
    localparam logic [1:0] OFS_DEC = 2'd0;
    localparam logic [1:0] OFS_SAME = 2'd1;
    localparam logic [1:0] OFS_INC = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_RD_WAIT,
        S_GEN,
        S_GEN_FLUSH,
        S_GEN_CLR,
        S_SCAN,
        S_SCAN_FLUSH,
        S_PUSH
    } t_state;

    typedef struct packed {
        t_cell  read_value;
        logic   found;
        t_coord found_x;
        t_coord found_y;
        t_coord found_z;
        logic   range_error;
    } t_result;

    // neighbor coordinate with toroidal wrap over the span
    function automatic t_coord nb_coord(input t_coord c, input logic [1:0] sel,
                                        input t_coord span);
        t_coord r;
        r = c;
        case (sel)
            OFS_DEC:  r = (c == '0) ? span - t_coord'(1) : c - t_coord'(1);
            OFS_INC:  r = (c == span - t_coord'(1)) ? '0 : c + t_coord'(1);
            default:  r = c;
        endcase
        return r;
    endfunction

endpackage

[design/pca3_bank.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pca3_bank: one cell bank
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module pca3_bank (
    input  logic           i_clk,
    input  logic           i_we,
    input  pca3_pkg::t_addr i_waddr,
    input  pca3_pkg::t_cell i_wdata,
    input  pca3_pkg::t_addr i_raddr,
    output pca3_pkg::t_cell o_rdata
);

    pca3_pkg::t_cell r_mem [pca3_pkg::DEPTH];
    pca3_pkg::t_cell r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/parity_cellular_automaton_3d_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parity_cellular_automaton_3d_top: 3D parity cellular automaton
// Cube of 4-bit cell types in two banks; write, read, generation and scan.
// ----------------------------------------------------------------------------
// Sweeps: scan and generation visit all span^3 cells (span = 2*radius+1);
//   generation reads 27 neighbors per cell.
// Throughput: one item at a time; the generation is bound by the single
//   read port of the current bank (one neighbor fetch per cycle).
// Reset: synchronous active low; radius 6, bank a current, output empty.
//   Cell memories are not cleared.
// ----------------------------------------------------------------------------
module parity_cellular_automaton_3d_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [4:0]  i_cell_x,
    input  logic [4:0]  i_cell_y,
    input  logic [4:0]  i_cell_z,
    input  logic [3:0]  i_cell_value,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_read_value,
    output logic        o_found,
    output logic [4:0]  o_found_x,
    output logic [4:0]  o_found_y,
    output logic [4:0]  o_found_z,
    output logic        o_range_error
);

    // ---------------- registers ----------------
    pca3_pkg::t_state  r_state, n_state;
    pca3_pkg::t_kind   r_kind, n_kind;
    pca3_pkg::t_coord  r_x, n_x, r_y, n_y, r_z, n_z;
    pca3_pkg::t_cell   r_val, n_val;
    logic [3:0]        r_radius;
    logic              r_active, n_active;
    // sweep position (cell) and neighbor offsets
    pca3_pkg::t_coord  r_cx, n_cx, r_cy, n_cy, r_cz, n_cz;
    logic [1:0]        r_a, n_a, r_b, n_b, r_c, n_c;
    // read issued last cycle: tags travel alongside the memory latency
    logic              r_iss_v, n_iss_v;
    logic              r_iss_ctr, n_iss_ctr;
    logic              r_iss_last, n_iss_last;
    pca3_pkg::t_addr   r_iss_cell, n_iss_cell;
    // running neighbor parities and center value
    logic              r_par_c, n_par_c, r_par_e, n_par_e;
    pca3_pkg::t_cell   r_old, n_old;
    pca3_pkg::t_result r_res, n_res;
    pca3_pkg::t_result r_out, n_out;
    logic              r_ov, n_ov;

    // ---------------- memory ports ----------------
    pca3_pkg::t_addr rd_addr, wr_addr;
    pca3_pkg::t_cell wr_data, rd_a, rd_b, rdata;
    logic            we_cur, we_nxt;
    logic            we_a, we_b;

    pca3_bank u_bank_a (
        .i_clk  (i_clk),
        .i_we   (we_a),
        .i_waddr(wr_addr),
        .i_wdata(wr_data),
        .i_raddr(rd_addr),
        .o_rdata(rd_a)
    );

    pca3_bank u_bank_b (
        .i_clk  (i_clk),
        .i_we   (we_b),
        .i_waddr(wr_addr),
        .i_wdata(wr_data),
        .i_raddr(rd_addr),
        .o_rdata(rd_b)
    );

    // bank a is written when it is current for cell writes, or the target
    // of a generation otherwise
    assign we_a = (we_cur && !r_active) || (we_nxt && r_active);
    assign we_b = (we_cur && r_active) || (we_nxt && !r_active);
    assign rdata = r_active ? rd_b : rd_a;

    // ---------------- config port ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {28'd0, r_radius} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 4'd6;
        end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
            r_radius <= pwdata[3:0];
        end
    end

    // ---------------- control ----------------
    pca3_pkg::t_coord span, span_m1;
    logic             cell_last, nb_last, par_c, par_e, in_range;
    pca3_pkg::t_cell  old_v, new_v;

    assign span    = {r_radius, 1'b1};
    assign span_m1 = span - pca3_pkg::t_coord'(1);
    assign o_in_stall = (r_state != pca3_pkg::S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_x        = r_x;
        n_y        = r_y;
        n_z        = r_z;
        n_val      = r_val;
        n_active   = r_active;
        n_cx       = r_cx;
        n_cy       = r_cy;
        n_cz       = r_cz;
        n_a        = r_a;
        n_b        = r_b;
        n_c        = r_c;
        n_iss_v    = 1'b0;
        n_iss_ctr  = 1'b0;
        n_iss_last = 1'b0;
        n_iss_cell = r_iss_cell;
        n_par_c    = r_par_c;
        n_par_e    = r_par_e;
        n_old      = r_old;
        n_res      = r_res;
        n_out      = r_out;
        n_ov       = r_ov && i_out_stall;
        rd_addr    = {r_cx, r_cy, r_cz};
        wr_addr    = {r_x, r_y, r_z};
        wr_data    = r_val;
        we_cur     = 1'b0;
        we_nxt     = 1'b0;
        cell_last  = (r_cx == span_m1) && (r_cy == span_m1) && (r_cz == span_m1);
        nb_last    = (r_a == pca3_pkg::OFS_INC) && (r_b == pca3_pkg::OFS_INC)
                     && (r_c == pca3_pkg::OFS_INC);
        in_range   = (r_x < span) && (r_y < span) && (r_z < span);
        par_c      = r_par_c ^ (rdata == pca3_pkg::T_CONCRETE);
        par_e      = r_par_e ^ (rdata == pca3_pkg::T_EMPTY);
        old_v      = r_iss_ctr ? rdata : r_old;
        new_v      = old_v;
        if (old_v == pca3_pkg::T_CONCRETE && par_c) begin
            new_v = pca3_pkg::T_EMPTY;
        end
        if (old_v == pca3_pkg::T_EMPTY && par_e) begin
            new_v = pca3_pkg::T_CONCRETE;
        end

        // returned read data of a sweep
        if (r_iss_v) begin
            if (r_kind == pca3_pkg::K_GEN) begin
                n_old = old_v;
                if (r_iss_last) begin
                    we_nxt  = 1'b1;
                    wr_addr = r_iss_cell;
                    wr_data = new_v;
                    n_par_c = 1'b0;
                    n_par_e = 1'b0;
                end else begin
                    n_par_c = par_c;
                    n_par_e = par_e;
                end
            end else if (rdata == pca3_pkg::T_MARKER) begin
                n_res.found   = 1'b1;
                n_res.found_x = r_iss_cell[3*pca3_pkg::COORD_W-1:2*pca3_pkg::COORD_W];
                n_res.found_y = r_iss_cell[2*pca3_pkg::COORD_W-1:pca3_pkg::COORD_W];
                n_res.found_z = r_iss_cell[pca3_pkg::COORD_W-1:0];
            end
        end

        case (r_state)
            pca3_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_kind  = pca3_pkg::t_kind'(i_kind);
                    n_x     = i_cell_x;
                    n_y     = i_cell_y;
                    n_z     = i_cell_z;
                    n_val   = i_cell_value;
                    n_state = pca3_pkg::S_EXEC;
                end
            end
            pca3_pkg::S_EXEC: begin
                n_res   = '0;
                n_cx    = '0;
                n_cy    = '0;
                n_cz    = '0;
                n_a     = '0;
                n_b     = '0;
                n_c     = '0;
                n_par_c = 1'b0;
                n_par_e = 1'b0;
                if (r_kind == pca3_pkg::K_SCAN) begin
                    n_state = pca3_pkg::S_SCAN;
                end else if (!in_range) begin
                    n_res.range_error = 1'b1;
                    n_state = pca3_pkg::S_PUSH;
                end else if (r_kind == pca3_pkg::K_WRITE) begin
                    we_cur  = 1'b1;
                    n_state = pca3_pkg::S_PUSH;
                end else if (r_kind == pca3_pkg::K_READ) begin
                    rd_addr = {r_x, r_y, r_z};
                    n_state = pca3_pkg::S_RD_WAIT;
                end else begin
                    n_state = pca3_pkg::S_GEN;
                end
            end
            pca3_pkg::S_RD_WAIT: begin
                n_res.read_value = rdata;
                n_state = pca3_pkg::S_PUSH;
            end
            pca3_pkg::S_GEN: begin
                rd_addr = {pca3_pkg::nb_coord(r_cx, r_a, span),
                           pca3_pkg::nb_coord(r_cy, r_b, span),
                           pca3_pkg::nb_coord(r_cz, r_c, span)};
                n_iss_v    = 1'b1;
                n_iss_ctr  = (r_a == pca3_pkg::OFS_SAME) && (r_b == pca3_pkg::OFS_SAME)
                             && (r_c == pca3_pkg::OFS_SAME);
                n_iss_last = nb_last;
                n_iss_cell = {r_cx, r_cy, r_cz};
                if (r_c != pca3_pkg::OFS_INC) begin
                    n_c = r_c + 2'd1;
                end else begin
                    n_c = '0;
                    if (r_b != pca3_pkg::OFS_INC) begin
                        n_b = r_b + 2'd1;
                    end else begin
                        n_b = '0;
                        if (r_a != pca3_pkg::OFS_INC) begin
                            n_a = r_a + 2'd1;
                        end else begin
                            n_a = '0;
                            if (cell_last) begin
                                n_state = pca3_pkg::S_GEN_FLUSH;
                            end else if (r_cz != span_m1) begin
                                n_cz = r_cz + pca3_pkg::t_coord'(1);
                            end else begin
                                n_cz = '0;
                                if (r_cy != span_m1) begin
                                    n_cy = r_cy + pca3_pkg::t_coord'(1);
                                end else begin
                                    n_cy = '0;
                                    n_cx = r_cx + pca3_pkg::t_coord'(1);
                                end
                            end
                        end
                    end
                end
            end
            pca3_pkg::S_GEN_FLUSH: begin
                // last cell is written back this cycle
                n_state = pca3_pkg::S_GEN_CLR;
            end
            pca3_pkg::S_GEN_CLR: begin
                // clear the player cell in the new bank, then swap
                we_nxt   = 1'b1;
                wr_addr  = {r_x, r_y, r_z};
                wr_data  = pca3_pkg::T_EMPTY;
                n_active = !r_active;
                n_state  = pca3_pkg::S_PUSH;
            end
            pca3_pkg::S_SCAN: begin
                rd_addr    = {r_cx, r_cy, r_cz};
                n_iss_v    = 1'b1;
                n_iss_cell = {r_cx, r_cy, r_cz};
                if (cell_last) begin
                    n_state = pca3_pkg::S_SCAN_FLUSH;
                end else if (r_cz != span_m1) begin
                    n_cz = r_cz + pca3_pkg::t_coord'(1);
                end else begin
                    n_cz = '0;
                    if (r_cy != span_m1) begin
                        n_cy = r_cy + pca3_pkg::t_coord'(1);
                    end else begin
                        n_cy = '0;
                        n_cx = r_cx + pca3_pkg::t_coord'(1);
                    end
                end
            end
            pca3_pkg::S_SCAN_FLUSH: begin
                n_state = pca3_pkg::S_PUSH;
            end
            pca3_pkg::S_PUSH: begin
                // hand the result to the output register once it is free
                if (!r_ov || !i_out_stall) begin
                    n_out   = r_res;
                    n_ov    = 1'b1;
                    n_state = pca3_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pca3_pkg::S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pca3_pkg::S_IDLE;
            r_active <= 1'b0;
            r_ov     <= 1'b0;
            r_iss_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_ov     <= n_ov;
            r_iss_v  <= n_iss_v;
        end
    end

    // payload and sweep registers
    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_x        <= n_x;
        r_y        <= n_y;
        r_z        <= n_z;
        r_val      <= n_val;
        r_cx       <= n_cx;
        r_cy       <= n_cy;
        r_cz       <= n_cz;
        r_a        <= n_a;
        r_b        <= n_b;
        r_c        <= n_c;
        r_iss_ctr  <= n_iss_ctr;
        r_iss_last <= n_iss_last;
        r_iss_cell <= n_iss_cell;
        r_par_c    <= n_par_c;
        r_par_e    <= n_par_e;
        r_old      <= n_old;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    assign o_out_valid   = r_ov;
    assign o_read_value  = r_out.read_value;
    assign o_found       = r_out.found;
    assign o_found_x     = r_out.found_x;
    assign o_found_y     = r_out.found_y;
    assign o_found_z     = r_out.found_z;
    assign o_range_error = r_out.range_error;

endmodule

[design/pca3_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pca3_checker: port-level checks
// Output handshake and result field consistency of the automaton.
// ----------------------------------------------------------------------------
module pca3_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [3:0] o_read_value,
    input logic       o_found,
    input logic [4:0] o_found_x,
    input logic [4:0] o_found_y,
    input logic [4:0] o_found_z,
    input logic       o_range_error
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output transfer dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_read_value) && $stable(o_found))
        else $error("stalled result changed");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_range_error |-> !o_found && o_read_value == 4'd0)
        else $error("range error with payload");

    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_found_x == 5'd0 && o_found_y == 5'd0
                                    && o_found_z == 5'd0)
        else $error("coordinates without marker");

    a_scan_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |-> o_read_value == 4'd0)
        else $error("scan result carries read data");

endmodule

bind parity_cellular_automaton_3d_top pca3_checker u_pca3_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_read_value (o_read_value),
    .o_found      (o_found),
    .o_found_x    (o_found_x),
    .o_found_y    (o_found_y),
    .o_found_z    (o_found_z),
    .o_range_error(o_range_error)
);
